FILE: design/tprd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tprd_pkg
// Shared constants and types for the timer prescale / reload / duty block.
// ----------------------------------------------------------------------------
package tprd_pkg;

	// width of the timer counter that the reload value must fit
	localparam int COUNTER_BITS = 16;

	localparam int PPM_W   = 20;
	localparam int CLOCK_W = 32;
	localparam int FIELD_W = 16;

	// serial divider operand widths: dividend covers clock and ppm*reload,
	// divisor covers frequency, 2^COUNTER_BITS+1 and one million
	localparam int DIV_NW = (PPM_W + COUNTER_BITS > CLOCK_W) ? PPM_W + COUNTER_BITS : CLOCK_W;
	localparam int DIV_DW = (COUNTER_BITS + 1 > CLOCK_W) ? COUNTER_BITS + 1 : CLOCK_W;

	// serial multiplier product width
	localparam int MUL_W = PPM_W + COUNTER_BITS;

	// smallest p with floor(clk/(p*f)) <= limit+1 is floor(floor(clk/f)/(limit+2))+1
	localparam logic [DIV_DW-1:0] SPAN_FACTOR =
		DIV_DW'((64'd1 << COUNTER_BITS) + 64'd1);
	localparam logic [DIV_DW-1:0] PPM_FULL     = DIV_DW'(1000000);
	localparam logic [FIELD_W-1:0] MAX_DIVIDER = 16'hFFFF;

	localparam logic [CLOCK_W-1:0] CLOCK_RESET = 32'd240000000;

	// handshake status of a serial arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage
`default_nettype wire

FILE: design/tprd_serial_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tprd_serial_div
// Restoring divider, one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module tprd_serial_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [tprd_pkg::DIV_NW-1:0] dividend,
	input  wire logic [tprd_pkg::DIV_DW-1:0] divisor,
	output tprd_pkg::unit_stat_t             stat,
	output logic      [tprd_pkg::DIV_NW-1:0] quotient
);
	import tprd_pkg::*;

	localparam int CNT_W = $clog2(DIV_NW + 1);

	logic [DIV_DW-1:0] rem_q;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW-1:0] dsr_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DIV_DW:0]   trial;
	logic [DIV_DW:0]   diff;
	logic              fits;

	// shift in the next dividend bit and try to subtract
	assign trial = {rem_q, quo_q[DIV_NW-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule
`default_nettype wire

FILE: design/tprd_serial_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tprd_serial_mul
// Shift-add multiplier of duty ppm by reload, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module tprd_serial_mul (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic [tprd_pkg::PPM_W-1:0]        mplier,
	input  wire logic [tprd_pkg::COUNTER_BITS-1:0] mcand,
	output tprd_pkg::unit_stat_t                   stat,
	output logic      [tprd_pkg::MUL_W-1:0]        product
);
	import tprd_pkg::*;

	localparam int CNT_W = $clog2(PPM_W + 1);

	logic [MUL_W-1:0] acc_q;
	logic [MUL_W-1:0] mcand_q;
	logic [PPM_W-1:0] mplier_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(PPM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			acc_q    <= '0;
			mcand_q  <= MUL_W'(mcand);
			mplier_q <= mplier;
		end else if (busy_q) begin
			// add the shifted multiplicand where the multiplier bit is set
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q  <= {mcand_q[MUL_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[PPM_W-1:1]};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign product   = acc_q;

endmodule
`default_nettype wire

FILE: design/timer_prescale_reload_and_duty_calc.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timer_prescale_reload_and_duty_calc
// Works out timer prescaler and reload from a target frequency, and a
// compare value from a duty cycle in parts per million.
// ----------------------------------------------------------------------------
// Request words (req_valid / req_stall) carry op, frequency_hz and duty_ppm;
// each yields one response word (rsp_valid / rsp_stall) with prescale_value,
// reload_value, compare_value and status. cfg_wr_en / cfg_wr_data write the
// timer input clock; write only while no request is in flight.
// One request at a time: setup runs three serial divisions
// (clock/frequency, by 2^COUNTER_BITS+1, by the divider); duty runs a
// shift-add multiply and one division. A zero frequency answers without
// a division, a clock below the frequency after the first division and a
// divider overflow after the second.
// Reset clears the stored prescale and reload, returns the clock register
// to 240 MHz and drops any pending response. A stalled response holds; a
// finished computation waits for the output register, so a new request is
// taken while one response still waits, but not a second.
// ----------------------------------------------------------------------------
module timer_prescale_reload_and_duty_calc (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic        op,
	input  wire logic [31:0] frequency_hz,
	input  wire logic [19:0] duty_ppm,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic      [15:0] prescale_value,
	output logic      [15:0] reload_value,
	output logic      [15:0] compare_value,
	output logic             status
);
	import tprd_pkg::*;

	localparam logic OP_SETUP = 1'b0;
	localparam logic OP_DUTY  = 1'b1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV_T = 3'd1;
	localparam logic [2:0] ST_DIV_P = 3'd2;
	localparam logic [2:0] ST_DIV_Q = 3'd3;
	localparam logic [2:0] ST_MUL   = 3'd4;
	localparam logic [2:0] ST_DIV_C = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]              state_q;
	logic [CLOCK_W-1:0]      clock_q;
	logic [FIELD_W-1:0]      stored_prescale_q;
	logic [COUNTER_BITS-1:0] stored_reload_q;
	logic [CLOCK_W-1:0]      t_q;
	logic [FIELD_W-1:0]      psc_new_q;
	logic [FIELD_W-1:0]      cmp_q;
	logic                    fail_q;
	logic                    rsp_valid_q;

	logic                    div_start;
	logic [DIV_NW-1:0]       div_dividend;
	logic [DIV_DW-1:0]       div_divisor;
	unit_stat_t              div_stat;
	logic [DIV_NW-1:0]       div_quo;

	logic                    mul_start;
	unit_stat_t              mul_stat;
	logic [MUL_W-1:0]        mul_prod;

	tprd_serial_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	tprd_serial_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mplier  (duty_ppm),
		.mcand   (stored_reload_q),
		.stat    (mul_stat),
		.product (mul_prod)
	);

	assign req_stall = (state_q != ST_IDLE);

	// start and operand select for the shared divider and the multiplier
	always_comb begin
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		mul_start    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (op == OP_DUTY) begin
						mul_start = 1'b1;
					end else if (frequency_hz != 32'd0) begin
						div_start    = 1'b1;
						div_dividend = DIV_NW'(clock_q);
						div_divisor  = DIV_DW'(frequency_hz);
					end
				end
			end
			ST_DIV_T: begin
				if (div_stat.done && div_quo != '0) begin
					div_start    = 1'b1;
					div_dividend = div_quo;
					div_divisor  = SPAN_FACTOR;
				end
			end
			ST_DIV_P: begin
				if (div_stat.done && div_quo < DIV_NW'(MAX_DIVIDER)) begin
					div_start    = 1'b1;
					div_dividend = DIV_NW'(t_q);
					div_divisor  = DIV_DW'({1'b0, div_quo[FIELD_W-1:0]} + 17'd1);
				end
			end
			ST_MUL: begin
				if (mul_stat.done) begin
					div_start    = 1'b1;
					div_dividend = DIV_NW'(mul_prod);
					div_divisor  = PPM_FULL;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			clock_q           <= CLOCK_RESET;
			stored_prescale_q <= '0;
			stored_reload_q   <= '0;
			rsp_valid_q       <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				clock_q <= cfg_wr_data;
			end
			// drop the taken word unless the next one loads at this edge
			if (rsp_valid_q && !rsp_stall && state_q != ST_DONE) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						if (op == OP_DUTY) begin
							state_q <= ST_MUL;
						end else if (frequency_hz == 32'd0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_DIV_T;
						end
					end
				end
				ST_DIV_T: begin
					if (div_stat.done) begin
						// zero quotient means the clock is below the frequency
						state_q <= (div_quo == '0) ? ST_DONE : ST_DIV_P;
					end
				end
				ST_DIV_P: begin
					if (div_stat.done) begin
						state_q <= (div_quo >= DIV_NW'(MAX_DIVIDER)) ? ST_DONE : ST_DIV_Q;
					end
				end
				ST_DIV_Q: begin
					if (div_stat.done) begin
						if (div_quo != '0) begin
							stored_prescale_q <= psc_new_q;
							stored_reload_q   <= COUNTER_BITS'(div_quo - DIV_NW'(1));
						end
						state_q <= ST_DONE;
					end
				end
				ST_MUL: begin
					if (mul_stat.done) begin
						state_q <= ST_DIV_C;
					end
				end
				ST_DIV_C: begin
					if (div_stat.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmp_q  <= '0;
					fail_q <= (op == OP_SETUP) && (frequency_hz == 32'd0);
				end
			end
			ST_DIV_T: begin
				if (div_stat.done) begin
					t_q <= div_quo[CLOCK_W-1:0];
					if (div_quo == '0) begin
						fail_q <= 1'b1;
					end
				end
			end
			ST_DIV_P: begin
				if (div_stat.done) begin
					psc_new_q <= div_quo[FIELD_W-1:0];
					if (div_quo >= DIV_NW'(MAX_DIVIDER)) begin
						fail_q <= 1'b1;
					end
				end
			end
			ST_DIV_Q: begin
				if (div_stat.done && div_quo == '0) begin
					fail_q <= 1'b1;
				end
			end
			ST_DIV_C: begin
				if (div_stat.done) begin
					// saturate to the reload for duty above full scale
					if (div_quo > DIV_NW'(stored_reload_q)) begin
						cmp_q <= FIELD_W'(stored_reload_q);
					end else begin
						cmp_q <= div_quo[FIELD_W-1:0];
					end
				end
			end
			ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					prescale_value <= stored_prescale_q;
					reload_value   <= FIELD_W'(stored_reload_q);
					compare_value  <= cmp_q;
					status         <= fail_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted but block not busy");

	a_no_start_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy)
		else $error("divider restarted while busy");

	a_fail_no_compare: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status |-> compare_value == 16'd0)
		else $error("failed setup carries a compare value");

	a_compare_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> compare_value <= reload_value)
		else $error("compare above reload");

endmodule
`default_nettype wire
